FILE: rtl/sjh_pkg.sv
package sjh_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int AX_BITS = ANGLE_BITS + 1;
  localparam int KEY_COUNT = 10;
  localparam int NUM_JOINTS = 4;

  localparam logic [3:0] KEY_HOME = 4'd8;
  localparam logic [3:0] KEY_VACUUM = 4'd9;

  localparam logic [3:0] INC_KEY [NUM_JOINTS] = '{4'd0, 4'd3, 4'd4, 4'd6};
  localparam logic [3:0] DEC_KEY [NUM_JOINTS] = '{4'd1, 4'd2, 4'd5, 4'd7};

  localparam logic [2:0] TGT_VACUUM = 3'd4;
  localparam logic [3:0] LAST_STEP = 4'd8;
  localparam logic [3:0] FIRST_JOG_STEP = 4'd4;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef logic [KEY_COUNT-1:0] key_mask_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [AX_BITS-1:0] angx_t;

  localparam angx_t ANG_ZERO = AX_BITS'(0);
  localparam angx_t ANG_ONE = AX_BITS'(1);
  localparam angx_t ANG_MINUS_ONE = AX_BITS'(-1);
  localparam angx_t ANG_TWO = AX_BITS'(2);
  localparam angx_t ANG_MINUS_TWO = AX_BITS'(-2);
  localparam angx_t ANG_SKIP_A1 = AX_BITS'(55);
  localparam angx_t ANG_WRIST_HOME = AX_BITS'(-40);
  localparam angx_t ANG_SHOULDER_HOME = AX_BITS'(30);
  localparam angx_t ANG_ELBOW_A1 = AX_BITS'(20);
  localparam angx_t ANG_WRIST_A1 = AX_BITS'(50);

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] key_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         target;
    logic signed [15:0] value;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic      push;
    key_mask_t keys;
  } tick_req_t;

  function automatic logic signed [15:0] angle_to_value(input angle_t a);
    logic [ANGLE_BITS+15:0] w;
    w = (ANGLE_BITS + 16)'(unsigned'(a));
    return signed'(w[15:0]);
  endfunction

endpackage

FILE: rtl/sjh_front.sv
module sjh_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  sjh_pkg::in_item_t  in_item,
  input  logic               q_full,
  output sjh_pkg::tick_req_t q_req
);
  import sjh_pkg::*;

  key_mask_t key_held_r;
  key_mask_t key_held_nxt;
  key_mask_t key_sel;
  logic      accept;

  assign accept = in_push && !q_full;

  always_comb begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      key_sel[k] = (in_item.key_id == 4'(k));
    end
    key_held_nxt = key_held_r;
    q_req.push = 1'b0;
    q_req.keys = key_held_r;
    if (accept) begin
      case (in_item.command)
        CMD_PRESS: key_held_nxt = key_held_r | key_sel;
        CMD_RELEASE: key_held_nxt = key_held_r & ~key_sel;
        CMD_TICK: begin
          q_req.push = 1'b1;
          key_held_nxt[KEY_VACUUM] = 1'b0;
        end
        default: key_held_nxt = key_held_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_held_r <= '0;
    end else begin
      key_held_r <= key_held_nxt;
    end
  end

endmodule

FILE: rtl/sjh_queue.sv
module sjh_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  sjh_pkg::tick_req_t q_req,
  output logic               q_full,
  input  logic               q_pop,
  output logic               q_empty,
  output sjh_pkg::key_mask_t q_data
);
  import sjh_pkg::*;

  key_mask_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign q_full = (count_r == 2'd2);
  assign q_empty = (count_r == 2'd0);
  assign q_data = mem_r[rd_ptr_r];
  assign do_push = q_req.push && !q_full;
  assign do_pop = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_req.keys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10: count_r <= count_r + 2'd1;
        2'b01: count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/sjh_back.sv
module sjh_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  sjh_pkg::key_mask_t  q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output sjh_pkg::out_item_t  out_item
);
  import sjh_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t    state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  key_mask_t keys_r, keys_nxt;
  angle_t    angle_r [NUM_JOINTS];
  angle_t    angle_nxt [NUM_JOINTS];
  logic      vacuum_r, vacuum_nxt;
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  logic [1:0] jn;
  angx_t     a0, a1, a3, cur, tgt, dlt, sum;
  logic [NUM_JOINTS-1:0] jog_map;
  logic      emit, last, later, skip, advance;

  assign out_empty = !out_valid_r;
  assign out_item = out_r;

  always_comb begin
    jn = step_r[1:0];
    a0 = angx_t'(angle_r[0]);
    a1 = angx_t'(angle_r[1]);
    a3 = angx_t'(angle_r[3]);
    cur = angx_t'(angle_r[jn]);
    for (int k = 0; k < NUM_JOINTS; k++) begin
      jog_map[k] = keys_r[INC_KEY[k]] | keys_r[DEC_KEY[k]];
    end
    tgt = ANG_ZERO;
    dlt = ANG_ZERO;
    skip = 1'b0;
    later = 1'b0;
    emit = 1'b0;
    last = 1'b0;
    if (step_r < FIRST_JOG_STEP) begin
      skip = (a1 > ANG_SKIP_A1) && (a3 != ANG_WRIST_HOME) && (jn != 2'd3);
      if (jn == 2'd0 && a0 != ANG_ZERO && a1 != ANG_SHOULDER_HOME) begin
        tgt = a0;
      end else if (jn == 2'd1 && a0 != ANG_ZERO) begin
        tgt = ANG_SHOULDER_HOME;
      end else if (jn == 2'd2 && (a0 != ANG_ZERO || a1 > ANG_ELBOW_A1)) begin
        tgt = a1 + ANG_SHOULDER_HOME;
      end else if (jn == 2'd3 && a1 > ANG_WRIST_A1) begin
        tgt = ANG_WRIST_HOME;
      end
      if ((jn == 2'd0 || jn == 2'd3) && cur != ANG_ONE && cur != ANG_MINUS_ONE) begin
        dlt = (cur < tgt) ? ANG_TWO : ((cur > tgt) ? ANG_MINUS_TWO : ANG_ZERO);
      end else begin
        dlt = (cur < tgt) ? ANG_ONE : ((cur > tgt) ? ANG_MINUS_ONE : ANG_ZERO);
      end
      emit = keys_r[KEY_HOME] && !skip;
      last = (jn == 2'd3) && !(|jog_map) && !keys_r[KEY_VACUUM];
    end else if (step_r < LAST_STEP) begin
      dlt = keys_r[INC_KEY[jn]] ? ANG_ONE : ANG_MINUS_ONE;
      emit = jog_map[jn];
      for (int k = 0; k < NUM_JOINTS; k++) begin
        if (2'(k) > jn) begin
          later = later | jog_map[k];
        end
      end
      last = !later && !keys_r[KEY_VACUUM];
    end else begin
      emit = keys_r[KEY_VACUUM];
      last = 1'b1;
    end
    sum = cur + dlt;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    keys_nxt = keys_r;
    angle_nxt = angle_r;
    vacuum_nxt = vacuum_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop = 1'b0;
    advance = (state_r == ST_RUN) && (!out_valid_r || out_pop);
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          keys_nxt = q_data;
          step_nxt = 4'd0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance) begin
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_nxt.last = last;
            if (step_r < LAST_STEP) begin
              angle_nxt[jn] = sum[ANGLE_BITS-1:0];
              out_nxt.target = 3'(jn);
              out_nxt.value = angle_to_value(sum[ANGLE_BITS-1:0]);
            end else begin
              vacuum_nxt = !vacuum_r;
              out_nxt.target = TGT_VACUUM;
              out_nxt.value = 16'(!vacuum_r);
            end
          end
          if (step_r == LAST_STEP) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= 4'd0;
      keys_r <= '0;
      for (int k = 0; k < NUM_JOINTS; k++) begin
        angle_r[k] <= '0;
      end
      vacuum_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      keys_r <= keys_nxt;
      angle_r <= angle_nxt;
      vacuum_r <= vacuum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> step_r <= LAST_STEP)
    else $error("step counter out of range");

  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.target <= TGT_VACUUM)
    else $error("result target out of range");

  a_vacuum_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.target == TGT_VACUUM) |-> out_r.value[15:1] == '0)
    else $error("vacuum result is not 0 or 1");

  a_vacuum_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.target == TGT_VACUUM) |-> out_r.last)
    else $error("vacuum result is not the final item of its tick");

endmodule

FILE: rtl/servo_jog_homing_sequencer.sv
// Channel | Ports                      | Accepted when
// input   | in_push, in_full, in_item  | in_push && !in_full
// result  | out_pop, out_empty, out_item | out_pop && !out_empty
//
// A key press or release is not queued; it updates the key flags when it is accepted.
// A tick is queued in a two-entry queue with a copy of the key flags.
// A tick leaves the queue while the sequencer is idle; the sequencer then works through
// the nine steps of the tick in order, holding a step while the result register is not taken.
// The input side stalls only when two ticks are waiting in the queue.
// Reset is synchronous and clears the key flags, the angles and the vacuum flag.
module servo_jog_homing_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  sjh_pkg::in_item_t  in_item,
  input  logic               out_pop,
  output logic               out_empty,
  output sjh_pkg::out_item_t out_item
);
  import sjh_pkg::*;

  tick_req_t q_req;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  key_mask_t q_data;

  assign in_full = q_full;

  sjh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .q_full  (q_full),
    .q_req   (q_req)
  );

  sjh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_req   (q_req),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_data  (q_data)
  );

  sjh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

FILE: test/servo_jog_homing_sequencer_test.sv
`timescale 1ns / 1ps

module servo_jog_homing_sequencer_test;
  import sjh_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 500;
  localparam int SKIP_SHOULDER = 55;
  localparam int WRIST_HOME = -40;
  localparam int SHOULDER_HOME = 30;
  localparam int ELBOW_OFFSET = 30;
  localparam int ELBOW_SHOULDER = 20;
  localparam int WRIST_SHOULDER = 50;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_pop = 1'b0;
  logic      out_empty;
  out_item_t out_item;

  key_mask_t keys_down;
  angle_t    joint_pos [NUM_JOINTS];
  logic      vacuum_state;
  out_item_t arm_updates [$];
  int        mismatches = 0;
  int        stall_cycles = 0;
  int        items_sent = 0;
  bit        idle_in = 1'b1;
  bit        idle_out = 1'b1;

  servo_jog_homing_sequencer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_item (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic out_item_t joint_update(int tgt, angle_t v);
    out_item_t r;
    r.target = tgt[2:0];
    r.value = v;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic advance_arm(in_item_t it);
    out_item_t batch [$];
    int a0, a1, a3, cur, goal, step;
    case (cmd_e'(it.command))
      CMD_PRESS: begin
        if (it.key_id < KEY_COUNT) keys_down[it.key_id] = 1'b1;
      end
      CMD_RELEASE: begin
        if (it.key_id < KEY_COUNT) keys_down[it.key_id] = 1'b0;
      end
      CMD_TICK: begin
        if (keys_down[KEY_HOME]) begin
          for (int j = 0; j < NUM_JOINTS; j++) begin
            a0 = int'(joint_pos[0]);
            a1 = int'(joint_pos[1]);
            a3 = int'(joint_pos[3]);
            if (a1 > SKIP_SHOULDER && a3 != WRIST_HOME && j != 3) continue;
            if (j == 0 && a0 != 0 && a1 != SHOULDER_HOME) goal = a0;
            else if (j == 1 && a0 != 0) goal = SHOULDER_HOME;
            else if (j == 2 && (a0 != 0 || a1 > ELBOW_SHOULDER)) goal = a1 + ELBOW_OFFSET;
            else if (j == 3 && a1 > WRIST_SHOULDER) goal = WRIST_HOME;
            else goal = 0;
            cur = int'(joint_pos[j]);
            step = (cur < goal) ? 1 : ((cur > goal) ? -1 : 0);
            if ((j == 0 || j == 3) && cur != 1 && cur != -1) step = step * 2;
            joint_pos[j] = joint_pos[j] + angle_t'(step);
            batch = {batch, joint_update(j, joint_pos[j])};
          end
        end
        for (int j = 0; j < NUM_JOINTS; j++) begin
          if (keys_down[INC_KEY[j]]) begin
            joint_pos[j] = joint_pos[j] + angle_t'(1);
            batch = {batch, joint_update(j, joint_pos[j])};
          end else if (keys_down[DEC_KEY[j]]) begin
            joint_pos[j] = joint_pos[j] - angle_t'(1);
            batch = {batch, joint_update(j, joint_pos[j])};
          end
        end
        if (keys_down[KEY_VACUUM]) begin
          vacuum_state = !vacuum_state;
          keys_down[KEY_VACUUM] = 1'b0;
          batch = {batch, joint_update(int'(TGT_VACUUM), angle_t'(vacuum_state))};
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) arm_updates = {arm_updates, batch[i]};
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(in_item_t it);
    int gap;
    gap = idle_in ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    advance_arm(it);
    if (cmd_e'(it.command) == CMD_TICK ||
        (cmd_e'(it.command) != CMD_NONE && it.key_id < KEY_COUNT)) begin
      items_sent++;
    end
  endtask

  task automatic send_key(cmd_e c, int k);
    in_item_t it;
    it.command = c;
    it.key_id = k[3:0];
    send_item(it);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_key(CMD_TICK, $urandom_range(0, 15));
  endtask

  task automatic release_all();
    for (int k = 0; k < KEY_COUNT; k++) send_key(CMD_RELEASE, k);
  endtask

  task automatic test_quiet_and_unknown();
    send_key(CMD_TICK, 0);
    send_key(CMD_NONE, 15);
    send_key(CMD_PRESS, 10);
    send_key(CMD_PRESS, 15);
    send_key(CMD_RELEASE, 12);
    send_key(CMD_TICK, 15);
  endtask

  task automatic test_all_keys();
    for (int k = 0; k < KEY_COUNT; k++) send_key(CMD_PRESS, k);
    send_ticks(2);
    release_all();
    send_ticks(1);
  endtask

  task automatic test_vacuum();
    send_key(CMD_PRESS, KEY_VACUUM);
    send_ticks(2);
    send_key(CMD_PRESS, KEY_VACUUM);
    send_key(CMD_PRESS, KEY_HOME);
    send_ticks(1);
    send_key(CMD_RELEASE, KEY_HOME);
  endtask

  task automatic test_homing_walk();
    send_key(CMD_PRESS, INC_KEY[1]);
    send_ticks(62);
    send_key(CMD_RELEASE, INC_KEY[1]);
    send_key(CMD_PRESS, INC_KEY[3]);
    send_ticks(3);
    send_key(CMD_RELEASE, INC_KEY[3]);
    send_key(CMD_PRESS, KEY_HOME);
    send_ticks(50);
    send_key(CMD_PRESS, DEC_KEY[0]);
    send_ticks(4);
    send_key(CMD_RELEASE, DEC_KEY[0]);
    send_ticks(6);
    send_key(CMD_RELEASE, KEY_HOME);
  endtask

  task automatic test_random_mix();
    in_item_t it;
    while (items_sent < RANDOM_ITEMS) begin
      idle_in = $urandom_range(0, 4) != 0;
      idle_out = $urandom_range(0, 4) != 0;
      if ($urandom_range(0, 9) < 7) begin
        for (int k = 0; k < KEY_COUNT; k++) begin
          if ($urandom_range(0, (k == KEY_HOME) ? 1 : 3) == 0) send_key(CMD_PRESS, k);
        end
        send_ticks($urandom_range(1, 12));
        for (int k = 0; k < KEY_COUNT; k++) begin
          if (keys_down[k] && $urandom_range(0, 3) != 0) send_key(CMD_RELEASE, k);
        end
      end else begin
        it.command = 2'($urandom_range(0, 3));
        it.key_id = 4'($urandom_range(0, 15));
        send_item(it);
      end
    end
    idle_in = 1'b1;
    idle_out = 1'b1;
  endtask

  task automatic test_back_to_back_jog();
    idle_in = 1'b0;
    idle_out = 1'b0;
    release_all();
    for (int j = 0; j < NUM_JOINTS; j++) send_key(CMD_PRESS, DEC_KEY[j]);
    send_ticks(6);
    for (int j = 0; j < NUM_JOINTS; j++) send_key(CMD_RELEASE, DEC_KEY[j]);
    for (int j = 0; j < NUM_JOINTS; j++) send_key(CMD_PRESS, INC_KEY[j]);
    send_ticks(3);
    release_all();
    idle_in = 1'b1;
    idle_out = 1'b1;
  endtask

  initial begin
    out_pop = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      int gap;
      out_item_t want;
      gap = idle_out ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      if (arm_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: target %0d value %0d last %0b",
                   out_item.target, out_item.value, out_item.last);
        end
      end else begin
        want = arm_updates.pop_front();
        if (out_item.target !== want.target || out_item.value !== want.value ||
            out_item.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("expected target %0d value %0d last %0b",
                     want.target, want.value, want.last);
            $display("  actual target %0d value %0d last %0b",
                     out_item.target, out_item.value, out_item.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("servo_jog_homing_sequencer: mismatch");
        $finish;
      end
    end
  end

  initial begin
    keys_down = '0;
    foreach (joint_pos[j]) joint_pos[j] = '0;
    vacuum_state = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_quiet_and_unknown();
    test_all_keys();
    test_vacuum();
    test_homing_walk();
    test_random_mix();
    test_back_to_back_jog();
    in_push <= 1'b0;
    while (arm_updates.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("servo_jog_homing_sequencer: match");
    end else begin
      $display("servo_jog_homing_sequencer: mismatch");
    end
    $finish;
  end

endmodule
